// ===== sv/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// smq_pkg
// Shared types and constants of the stepper move sequencer: decoded operation
// codes, move codes, command characters and configuration register indexes.
// ----------------------------------------------------------------------------
package smq_pkg;

    // Width of one tick limit / tick counter
    localparam int TICK_W = 16;
    // Width of the configuration register index
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_XY_MOVE_TICKS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_FULL_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_PARTIAL_TICKS = 2'd2;

    // Configuration reset values
    localparam logic [TICK_W-1:0] XY_MOVE_TICKS_RST       = 16'd200;
    localparam logic [TICK_W-1:0] CRANK_FULL_TICKS_RST    = 16'd1600;
    localparam logic [TICK_W-1:0] CRANK_PARTIAL_TICKS_RST = 16'd160;

    // Command characters
    localparam logic [7:0] CHAR_STOP       = 8'h30;  // '0'
    localparam logic [7:0] CHAR_MOVE_FIRST = 8'h31;  // '1'
    localparam logic [7:0] CHAR_MOVE_LAST  = 8'h37;  // '7'

    // Move codes (low three bits of the command character)
    localparam logic [2:0] MOVE_IDLE      = 3'd0;
    localparam logic [2:0] MOVE_X_FWD     = 3'd1;
    localparam logic [2:0] MOVE_Y_FWD     = 3'd2;
    localparam logic [2:0] MOVE_X_REV     = 3'd3;
    localparam logic [2:0] MOVE_Y_REV     = 3'd4;
    localparam logic [2:0] MOVE_CRANK_PRT = 3'd5;
    localparam logic [2:0] MOVE_CRANK_FWD = 3'd6;
    localparam logic [2:0] MOVE_CRANK_REV = 3'd7;

    // Step line positions
    localparam logic [1:0] STEP_X     = 2'd0;
    localparam logic [1:0] STEP_Y     = 2'd1;
    localparam logic [1:0] STEP_CRANK = 2'd2;

    // Decoded operation kinds
    typedef enum logic [2:0] {
        OP_DROP = 3'd0,   // framing error: no echo, no change
        OP_ECHO = 3'd1,   // other byte: echo only
        OP_STOP = 3'd2,   // stop byte
        OP_MOVE = 3'd3,   // move byte
        OP_TICK = 3'd4    // timer tick
    } op_kind_t;

    // One decoded item as it travels through the queue
    typedef struct packed {
        op_kind_t   kind;
        logic [2:0] move;
        logic [7:0] rx_byte;
    } smq_op_t;

    // Tick limits handed to the execution side
    typedef struct packed {
        logic [TICK_W-1:0] xy_move_ticks;
        logic [TICK_W-1:0] crank_full_ticks;
        logic [TICK_W-1:0] crank_partial_ticks;
    } smq_limits_t;

endpackage

// ===== sv/stepper_move_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_move_sequencer_unit
// Stepper move sequencer: serial command bytes select moves, timer ticks
// toggle the chosen step line until the move's tick limit is reached.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_valid / s_ready  | command, rx_byte, framing_error
//  m_       | out       | m_valid / m_ready  | step/dir lines, move_mode, echo
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (tick limits)
//
//  One item per cycle sustained while results are taken; an item passes through
//  the decode register, the queue and the execution register into the result.
//  The execution stage updates all motion state for an item when it takes it.
//  Reset clears the motion state, loads the default tick limits, and leaves no
//  clearing pass; configuration writes are taken every cycle.
//  A stalled result holds the execution stage; the queue and the decode
//  register keep taking items until the queue is full.
//
module stepper_move_sequencer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          s_framing_error,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_x_step,
    output logic                          m_y_step,
    output logic                          m_xy_dir,
    output logic                          m_crank_step,
    output logic                          m_turn_dir,
    output logic [2:0]                    m_move_mode,
    output logic                          m_echo_valid,
    output logic [7:0]                    m_echo_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smq_pkg::TICK_W-1:0]    cfg_data
);

    smq_pkg::smq_limits_t limits_reg;
    smq_pkg::smq_limits_t limits_next;
    logic                 fr_valid;
    logic                 fr_ready;
    smq_pkg::smq_op_t     fr_op;
    logic                 q_valid;
    logic                 q_ready;
    smq_pkg::smq_op_t     q_op;

    // Tick limit registers; writes beyond the list are ignored
    assign cfg_ready = 1'b1;

    always_comb begin
        limits_next = limits_reg;
        if (cfg_valid) begin
            case (cfg_index)
                smq_pkg::REG_XY_MOVE_TICKS:       limits_next.xy_move_ticks       = cfg_data;
                smq_pkg::REG_CRANK_FULL_TICKS:    limits_next.crank_full_ticks    = cfg_data;
                smq_pkg::REG_CRANK_PARTIAL_TICKS: limits_next.crank_partial_ticks = cfg_data;
                default:                          limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limits_reg.xy_move_ticks       <= smq_pkg::XY_MOVE_TICKS_RST;
            limits_reg.crank_full_ticks    <= smq_pkg::CRANK_FULL_TICKS_RST;
            limits_reg.crank_partial_ticks <= smq_pkg::CRANK_PARTIAL_TICKS_RST;
        end else begin
            limits_reg <= limits_next;
        end
    end

    smq_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_rx_byte       (s_rx_byte),
        .s_framing_error (s_framing_error),
        .op_valid        (fr_valid),
        .op_ready        (fr_ready),
        .op              (fr_op)
    );

    smq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_op     (fr_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    smq_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .limits       (limits_reg),
        .op_valid     (q_valid),
        .op_ready     (q_ready),
        .op           (q_op),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_x_step     (m_x_step),
        .m_y_step     (m_y_step),
        .m_xy_dir     (m_xy_dir),
        .m_crank_step (m_crank_step),
        .m_turn_dir   (m_turn_dir),
        .m_move_mode  (m_move_mode),
        .m_echo_valid (m_echo_valid),
        .m_echo_byte  (m_echo_byte)
    );

endmodule

// ===== sv/smq_front.sv =====
// ----------------------------------------------------------------------------
// smq_front
// Input stage: takes items, classifies them into operations and holds one
// decoded operation until the queue takes it.
// ----------------------------------------------------------------------------
module smq_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_command,
    input  logic [7:0]       s_rx_byte,
    input  logic             s_framing_error,
    output logic             op_valid,
    input  logic             op_ready,
    output smq_pkg::smq_op_t op
);

    logic             op_valid_reg;
    logic             op_valid_next;
    smq_pkg::smq_op_t op_reg;
    smq_pkg::smq_op_t op_dec;

    // Classify the incoming item
    always_comb begin
        op_dec.move    = s_rx_byte[2:0];
        op_dec.rx_byte = s_rx_byte;
        if (s_command) begin
            op_dec.kind = smq_pkg::OP_TICK;
        end else if (s_framing_error) begin
            op_dec.kind = smq_pkg::OP_DROP;
        end else if (s_rx_byte == smq_pkg::CHAR_STOP) begin
            op_dec.kind = smq_pkg::OP_STOP;
        end else if (s_rx_byte >= smq_pkg::CHAR_MOVE_FIRST &&
                     s_rx_byte <= smq_pkg::CHAR_MOVE_LAST) begin
            op_dec.kind = smq_pkg::OP_MOVE;
        end else begin
            op_dec.kind = smq_pkg::OP_ECHO;
        end
    end

    // Take a new item when the holding register is empty or drains now
    assign s_ready  = !op_valid_reg || op_ready;
    assign op_valid = op_valid_reg;
    assign op       = op_reg;

    always_comb begin
        op_valid_next = op_valid_reg;
        if (s_ready) begin
            op_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg <= 1'b0;
        end else begin
            op_valid_reg <= op_valid_next;
        end
    end

    // Hold the decoded payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= op_dec;
        end
    end

endmodule

// ===== sv/smq_queue.sv =====
// ----------------------------------------------------------------------------
// smq_queue
// Small first-in first-out queue of decoded operations between the input
// stage and the execution stage.
// ----------------------------------------------------------------------------
module smq_queue #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  smq_pkg::smq_op_t in_op,
    output logic             out_valid,
    input  logic             out_ready,
    output smq_pkg::smq_op_t out_op
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    smq_pkg::smq_op_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed operation
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");

    // A lone push raises occupancy by one
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue occupancy not advanced on push");

endmodule

// ===== sv/smq_back.sv =====
// ----------------------------------------------------------------------------
// smq_back
// Execution stage: applies one operation to the motion state and presents
// the resulting line levels, move code and echo as one result.
// ----------------------------------------------------------------------------
module smq_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  smq_pkg::smq_limits_t limits,
    input  logic                 op_valid,
    output logic                 op_ready,
    input  smq_pkg::smq_op_t     op,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_x_step,
    output logic                 m_y_step,
    output logic                 m_xy_dir,
    output logic                 m_crank_step,
    output logic                 m_turn_dir,
    output logic [2:0]           m_move_mode,
    output logic                 m_echo_valid,
    output logic [7:0]           m_echo_byte
);

    localparam int TW = smq_pkg::TICK_W;

    logic          valid_reg,  valid_next;
    logic [2:0]    move_reg,   move_next;
    logic [TW-1:0] count_reg,  count_next;
    logic          phase_reg,  phase_next;
    logic [2:0]    step_reg,   step_next;
    logic          xy_dir_reg, xy_dir_next;
    logic          cr_dir_reg, cr_dir_next;
    logic          echo_valid_reg, echo_valid_next;
    logic [7:0]    echo_byte_reg,  echo_byte_next;

    logic          take;
    logic          moving;
    logic [TW-1:0] limit;
    logic [1:0]    line;
    logic          dir_crank;
    logic          dir_val;
    logic [TW-1:0] count_inc;

    // Result slot frees when empty or taken this cycle
    assign op_ready = !valid_reg || m_ready;
    assign take     = op_valid && op_ready;

    // Select limit, step line and direction of the active move
    always_comb begin
        moving    = 1'b1;
        limit     = limits.xy_move_ticks;
        line      = smq_pkg::STEP_X;
        dir_crank = 1'b0;
        dir_val   = 1'b1;
        case (move_reg)
            smq_pkg::MOVE_X_FWD: begin
                line = smq_pkg::STEP_X;
            end
            smq_pkg::MOVE_Y_FWD: begin
                line = smq_pkg::STEP_Y;
            end
            smq_pkg::MOVE_X_REV: begin
                line    = smq_pkg::STEP_X;
                dir_val = 1'b0;
            end
            smq_pkg::MOVE_Y_REV: begin
                line    = smq_pkg::STEP_Y;
                dir_val = 1'b0;
            end
            smq_pkg::MOVE_CRANK_PRT: begin
                limit     = limits.crank_partial_ticks;
                line      = smq_pkg::STEP_CRANK;
                dir_crank = 1'b1;
            end
            smq_pkg::MOVE_CRANK_FWD: begin
                limit     = limits.crank_full_ticks;
                line      = smq_pkg::STEP_CRANK;
                dir_crank = 1'b1;
            end
            smq_pkg::MOVE_CRANK_REV: begin
                limit     = limits.crank_full_ticks;
                line      = smq_pkg::STEP_CRANK;
                dir_crank = 1'b1;
                dir_val   = 1'b0;
            end
            default: begin
                moving = 1'b0;
            end
        endcase
    end

    assign count_inc = count_reg + 1'b1;

    // Apply one operation to the motion state
    always_comb begin
        valid_next      = valid_reg;
        move_next       = move_reg;
        count_next      = count_reg;
        phase_next      = phase_reg;
        step_next       = step_reg;
        xy_dir_next     = xy_dir_reg;
        cr_dir_next     = cr_dir_reg;
        echo_valid_next = echo_valid_reg;
        echo_byte_next  = echo_byte_reg;
        if (op_ready) begin
            valid_next = op_valid;
        end
        if (take) begin
            echo_valid_next = 1'b0;
            echo_byte_next  = '0;
            case (op.kind)
                smq_pkg::OP_ECHO: begin
                    echo_valid_next = 1'b1;
                    echo_byte_next  = op.rx_byte;
                end
                smq_pkg::OP_STOP: begin
                    echo_valid_next = 1'b1;
                    echo_byte_next  = op.rx_byte;
                    count_next      = '0;
                    move_next       = smq_pkg::MOVE_IDLE;
                    step_next       = '0;
                end
                smq_pkg::OP_MOVE: begin
                    echo_valid_next = 1'b1;
                    echo_byte_next  = op.rx_byte;
                    count_next      = '0;
                    move_next       = op.move;
                end
                smq_pkg::OP_TICK: begin
                    // Step only while the count has not passed the limit
                    if (moving && !(count_reg > limit)) begin
                        if (dir_crank) begin
                            cr_dir_next = dir_val;
                        end else begin
                            xy_dir_next = dir_val;
                        end
                        step_next[line] = !phase_reg;
                        phase_next      = !phase_reg;
                        count_next      = count_inc;
                        // Finish the move at the limit
                        if (count_inc == limit) begin
                            move_next       = smq_pkg::MOVE_IDLE;
                            step_next[line] = 1'b0;
                            phase_next      = 1'b0;
                        end
                    end
                end
                default: begin
                    // Framing error: drop the byte without echo, keep the motion state
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            move_reg       <= smq_pkg::MOVE_IDLE;
            count_reg      <= '0;
            phase_reg      <= 1'b0;
            step_reg       <= '0;
            xy_dir_reg     <= 1'b1;
            cr_dir_reg     <= 1'b1;
            echo_valid_reg <= 1'b0;
            echo_byte_reg  <= '0;
        end else begin
            valid_reg      <= valid_next;
            move_reg       <= move_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            xy_dir_reg     <= xy_dir_next;
            cr_dir_reg     <= cr_dir_next;
            echo_valid_reg <= echo_valid_next;
            echo_byte_reg  <= echo_byte_next;
        end
    end

    // Present the state after the last executed operation
    assign m_valid      = valid_reg;
    assign m_x_step     = step_reg[smq_pkg::STEP_X];
    assign m_y_step     = step_reg[smq_pkg::STEP_Y];
    assign m_crank_step = step_reg[smq_pkg::STEP_CRANK];
    assign m_xy_dir     = xy_dir_reg;
    assign m_turn_dir   = cr_dir_reg;
    assign m_move_mode  = move_reg;
    assign m_echo_valid = echo_valid_reg;
    assign m_echo_byte  = echo_byte_reg;

    // A stop leaves the block idle with every step line low
    a_stop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        take && op.kind == smq_pkg::OP_STOP |=>
            move_reg == smq_pkg::MOVE_IDLE && step_reg == '0)
        else $error("stop did not clear motion");

    // A dropped byte changes no motion state
    a_drop_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        take && op.kind == smq_pkg::OP_DROP |=>
            $stable(move_reg) && $stable(count_reg) && $stable(step_reg) && !echo_valid_reg)
        else $error("dropped byte changed state");

endmodule

// ===== tb/smq_move_checker.sv =====
// ----------------------------------------------------------------------------
// smq_move_checker
// Watches the item, result and register channels of the stepper move
// sequencer, keeps its own copy of the motion state and tick limits, predicts
// the line levels and echo for every accepted item, and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module smq_move_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_command,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          s_framing_error,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_x_step,
    input  logic                          m_y_step,
    input  logic                          m_xy_dir,
    input  logic                          m_crank_step,
    input  logic                          m_turn_dir,
    input  logic [2:0]                    m_move_mode,
    input  logic                          m_echo_valid,
    input  logic [7:0]                    m_echo_byte,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [smq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [smq_pkg::TICK_W-1:0]    cfg_data,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW        = smq_pkg::TICK_W;
    localparam int DIR_XY    = 0;
    localparam int DIR_CRANK = 1;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic       x_step;
        logic       y_step;
        logic       xy_dir;
        logic       crank_step;
        logic       turn_dir;
        logic [2:0] move_mode;
        logic       echo_valid;
        logic [7:0] echo_byte;
    } line_levels_t;

    // Tick limits
    logic [TW-1:0] lim_xy;
    logic [TW-1:0] lim_crank_full;
    logic [TW-1:0] lim_crank_part;

    // Motion state
    logic [2:0]    cur_move;
    logic [TW-1:0] tick_cnt;
    logic          phase;
    logic [2:0]    step_lv;
    logic [1:0]    dir_lv;

    line_levels_t expected_lines[$];
    int           result_no;

    // Advance the motion state by one item and return the line levels after it
    function automatic line_levels_t advance_motion(input logic cmd, input logic [7:0] rx,
                                                    input logic ferr);
        line_levels_t  res;
        logic [TW-1:0] lim;
        logic [1:0]    line;
        int            dpos;
        logic          dval;
        logic          moving;
        res    = '0;
        lim    = '0;
        line   = smq_pkg::STEP_X;
        dpos   = DIR_XY;
        dval   = 1'b0;
        moving = 1'b1;
        if (cmd) begin
            case (cur_move)
                smq_pkg::MOVE_X_FWD: begin
                    lim = lim_xy; line = smq_pkg::STEP_X; dpos = DIR_XY; dval = 1'b1;
                end
                smq_pkg::MOVE_Y_FWD: begin
                    lim = lim_xy; line = smq_pkg::STEP_Y; dpos = DIR_XY; dval = 1'b1;
                end
                smq_pkg::MOVE_X_REV: begin
                    lim = lim_xy; line = smq_pkg::STEP_X; dpos = DIR_XY; dval = 1'b0;
                end
                smq_pkg::MOVE_Y_REV: begin
                    lim = lim_xy; line = smq_pkg::STEP_Y; dpos = DIR_XY; dval = 1'b0;
                end
                smq_pkg::MOVE_CRANK_PRT: begin
                    lim = lim_crank_part; line = smq_pkg::STEP_CRANK;
                    dpos = DIR_CRANK; dval = 1'b1;
                end
                smq_pkg::MOVE_CRANK_FWD: begin
                    lim = lim_crank_full; line = smq_pkg::STEP_CRANK;
                    dpos = DIR_CRANK; dval = 1'b1;
                end
                smq_pkg::MOVE_CRANK_REV: begin
                    lim = lim_crank_full; line = smq_pkg::STEP_CRANK;
                    dpos = DIR_CRANK; dval = 1'b0;
                end
                default: moving = 1'b0;
            endcase
            // A count past the limit stalls the move without stepping
            if (moving && !(tick_cnt > lim)) begin
                dir_lv[dpos] = dval;
                step_lv[line] = ~phase;
                phase = ~phase;
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt == lim) begin
                    cur_move = smq_pkg::MOVE_IDLE;
                    step_lv[line] = 1'b0;
                    phase = 1'b0;
                end
            end
        end else if (!ferr) begin
            res.echo_valid = 1'b1;
            res.echo_byte  = rx;
            if (rx == smq_pkg::CHAR_STOP) begin
                tick_cnt = '0;
                cur_move = smq_pkg::MOVE_IDLE;
                step_lv  = '0;
            end else if (rx >= smq_pkg::CHAR_MOVE_FIRST && rx <= smq_pkg::CHAR_MOVE_LAST) begin
                tick_cnt = '0;
                cur_move = rx[2:0];
            end
        end
        res.x_step     = step_lv[smq_pkg::STEP_X];
        res.y_step     = step_lv[smq_pkg::STEP_Y];
        res.crank_step = step_lv[smq_pkg::STEP_CRANK];
        res.xy_dir     = dir_lv[DIR_XY];
        res.turn_dir   = dir_lv[DIR_CRANK];
        res.move_mode  = cur_move;
        return res;
    endfunction

    // Print one mismatch line and count it
    task automatic check_field(input string field, input int got, input int want);
        if (got != want) begin
            if (fail_count < PRINT_CAP)
                $display("result %0d: %s got %0d, expected %0d", result_no, field, got, want);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        line_levels_t want;
        if (!aresetn) begin
            lim_xy         = smq_pkg::XY_MOVE_TICKS_RST;
            lim_crank_full = smq_pkg::CRANK_FULL_TICKS_RST;
            lim_crank_part = smq_pkg::CRANK_PARTIAL_TICKS_RST;
            cur_move       = smq_pkg::MOVE_IDLE;
            tick_cnt       = '0;
            phase          = 1'b0;
            step_lv        = '0;
            dir_lv         = 2'b11;
            fail_count     = 0;
            result_no      = 0;
            expected_lines.delete();
        end else begin
            // Compare a result transfer with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_lines.size() == 0) begin
                    check_field("unexpected result", 1, 0);
                end else begin
                    want = expected_lines.pop_front();
                    check_field("x_step", int'(m_x_step), int'(want.x_step));
                    check_field("y_step", int'(m_y_step), int'(want.y_step));
                    check_field("xy_dir", int'(m_xy_dir), int'(want.xy_dir));
                    check_field("crank_step", int'(m_crank_step), int'(want.crank_step));
                    check_field("turn_dir", int'(m_turn_dir), int'(want.turn_dir));
                    check_field("move_mode", int'(m_move_mode), int'(want.move_mode));
                    check_field("echo_valid", int'(m_echo_valid), int'(want.echo_valid));
                    check_field("echo_byte", int'(m_echo_byte), int'(want.echo_byte));
                end
                result_no++;
            end
            // Predict an item transfer
            if (s_valid && s_ready)
                expected_lines.push_back(advance_motion(s_command, s_rx_byte,
                                                        s_framing_error));
            // Track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    smq_pkg::REG_XY_MOVE_TICKS:       lim_xy = cfg_data;
                    smq_pkg::REG_CRANK_FULL_TICKS:    lim_crank_full = cfg_data;
                    smq_pkg::REG_CRANK_PARTIAL_TICKS: lim_crank_part = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = expected_lines.size();
    end

endmodule

// ===== tb/tb_stepper_move_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_stepper_move_sequencer_unit
// Drives serial bytes, timer ticks and tick limit writes into the stepper move
// sequencer with random gaps and result stalls; a checker beside the block
// predicts and compares every result and the count decides the verdict.
// ----------------------------------------------------------------------------
module tb_stepper_move_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int TW = smq_pkg::TICK_W;
    localparam int IW = smq_pkg::CFG_IDX_W;
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam logic [IW-1:0] REG_UNUSED = 2'd3;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic          s_valid         = 1'b0;
    logic          s_ready;
    logic          s_command       = 1'b0;
    logic [7:0]    s_rx_byte       = '0;
    logic          s_framing_error = 1'b0;
    logic          m_valid;
    logic          m_ready         = 1'b0;
    logic          m_x_step;
    logic          m_y_step;
    logic          m_xy_dir;
    logic          m_crank_step;
    logic          m_turn_dir;
    logic [2:0]    m_move_mode;
    logic          m_echo_valid;
    logic [7:0]    m_echo_byte;
    logic          cfg_valid       = 1'b0;
    logic          cfg_ready;
    logic [IW-1:0] cfg_index       = '0;
    logic [TW-1:0] cfg_data        = '0;

    int fail_count;
    int pending;
    int cycles = 0;

    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;
    logic result_taken = 1'b0;
    int   ready_hold   = 0;

    always #1 aclk = ~aclk;

    stepper_move_sequencer_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_rx_byte       (s_rx_byte),
        .s_framing_error (s_framing_error),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_step        (m_x_step),
        .m_y_step        (m_y_step),
        .m_xy_dir        (m_xy_dir),
        .m_crank_step    (m_crank_step),
        .m_turn_dir      (m_turn_dir),
        .m_move_mode     (m_move_mode),
        .m_echo_valid    (m_echo_valid),
        .m_echo_byte     (m_echo_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    smq_move_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_rx_byte       (s_rx_byte),
        .s_framing_error (s_framing_error),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_x_step        (m_x_step),
        .m_y_step        (m_y_step),
        .m_xy_dir        (m_xy_dir),
        .m_crank_step    (m_crank_step),
        .m_turn_dir      (m_turn_dir),
        .m_move_mode     (m_move_mode),
        .m_echo_valid    (m_echo_valid),
        .m_echo_byte     (m_echo_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("stepper_move_sequencer_unit: mismatch");
            $finish;
        end
    end

    // Remember whether a result transfer happened at this edge
    always @(posedge aclk) begin
        result_taken <= m_valid && m_ready;
    end

    // Randomly stall the result side after each transfer unless the sink is calm
    always @(negedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (result_taken) begin
            w = sink_calm ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
                m_ready    <= 1'b0;
                ready_hold <= w - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic cmd, input logic [7:0] rx, input logic ferr);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_rx_byte       <= rx;
        s_framing_error <= ferr;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_byte(input logic [7:0] rx);
        send_item(CMD_BYTE, rx, 1'b0);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, 8'($urandom), 1'($urandom));
    endtask

    // Drop valid, wait for every predicted result, then settle for SETTLE_CYCLES
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One register write transfer, after which cfg_valid is dropped again
    task automatic write_reg(input logic [IW-1:0] idx, input logic [TW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_limits(input logic [TW-1:0] xy, input logic [TW-1:0] full,
                              input logic [TW-1:0] part);
        drain();
        write_reg(smq_pkg::REG_XY_MOVE_TICKS, xy);
        write_reg(smq_pkg::REG_CRANK_FULL_TICKS, full);
        write_reg(smq_pkg::REG_CRANK_PARTIAL_TICKS, part);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    // Mostly ticks, then moves, with stops, stray bytes and framing errors
    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            send_tick();
        else if (r < 78)
            send_byte(smq_pkg::CHAR_MOVE_FIRST + 8'($urandom_range(0, 6)));
        else if (r < 82)
            send_byte(smq_pkg::CHAR_STOP);
        else if (r < 90)
            send_byte(8'($urandom));
        else if (r < 95)
            send_item(CMD_BYTE, smq_pkg::CHAR_STOP + 8'($urandom_range(0, 7)), 1'b1);
        else
            send_item(CMD_BYTE, 8'($urandom), 1'b1);
    endtask

    initial begin
        logic [TW-1:0] xy, full, part;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Idle tick, stop while idle, stray bytes, dropped move byte
        send_item(CMD_TICK, 8'hFF, 1'b1);
        send_byte(smq_pkg::CHAR_STOP);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_item(CMD_BYTE, smq_pkg::CHAR_MOVE_FIRST, 1'b1);

        // Short limits: complete moves, retarget mid-move, stop mid-move
        set_limits(16'd2, 16'd3, 16'd1);
        send_byte(smq_pkg::CHAR_MOVE_FIRST);
        send_tick();
        send_tick();
        send_tick();
        send_byte(smq_pkg::CHAR_MOVE_FIRST + 8'd3);
        send_tick();
        send_byte(smq_pkg::CHAR_MOVE_FIRST + 8'd5);
        send_tick();
        send_tick();
        send_tick();
        send_byte(smq_pkg::CHAR_MOVE_FIRST + 8'd4);
        send_tick();
        send_byte(smq_pkg::CHAR_MOVE_LAST);
        send_tick();
        send_byte(smq_pkg::CHAR_STOP);

        // Limit lowered below the count stalls the move
        set_limits(16'd5, 16'd3, 16'd1);
        send_byte(smq_pkg::CHAR_MOVE_FIRST + 8'd1);
        send_tick();
        send_tick();
        send_tick();
        set_limits(16'd1, 16'd3, 16'd0);
        send_tick();
        send_byte(smq_pkg::CHAR_STOP);

        // Zero limit on the partial crank move
        send_byte(smq_pkg::CHAR_MOVE_FIRST + 8'd4);
        send_tick();
        send_tick();
        send_byte(smq_pkg::CHAR_STOP);

        // Random phases over several limit settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin xy = 16'd1; full = 16'd1; part = 16'd1; end
                1: begin xy = 16'hFFFF; full = 16'hFFFF; part = 16'hFFFF; end
                2: begin
                    xy   = 16'($urandom_range(1, 8));
                    full = 16'($urandom_range(1, 8));
                    part = 16'($urandom_range(1, 8));
                end
                3: begin
                    xy   = 16'($urandom_range(1, 40));
                    full = 16'($urandom_range(1, 40));
                    part = 16'($urandom_range(1, 40));
                end
                4: begin
                    xy   = 16'($urandom_range(1, 12));
                    full = 16'($urandom);
                    part = 16'($urandom_range(1, 20));
                end
                default: begin
                    xy   = smq_pkg::XY_MOVE_TICKS_RST;
                    full = smq_pkg::CRANK_FULL_TICKS_RST;
                    part = smq_pkg::CRANK_PARTIAL_TICKS_RST;
                end
            endcase
            set_limits(xy, full, part);
            src_calm  = (p == 2) || (p == 4);
            sink_calm = (p == 3) || (p == 4);
            repeat (PHASE_ITEMS) send_random_item();
        end

        drain();
        if (fail_count == 0)
            $display("stepper_move_sequencer_unit: match");
        else
            $display("stepper_move_sequencer_unit: mismatch");
        $finish;
    end

endmodule

// ===== stepper_move_sequencer_unit.f =====
sv/smq_pkg.sv
sv/smq_front.sv
sv/smq_queue.sv
sv/smq_back.sv
sv/stepper_move_sequencer_unit.sv
tb/smq_move_checker.sv
tb/tb_stepper_move_sequencer_unit.sv
